@@ design/first_fit_free_list_allocator_assert.svh @@
// assertion macros for the first-fit free-list allocator
// expects clk and rst_n in the scope of use, no other dependencies
`ifndef FIRST_FIT_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_FREE_LIST_ALLOCATOR_ASSERT_SVH
`ifndef ASSERT_OFF
`define FFA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ffa: same-cycle check failed");
`define FFA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ffa: next-cycle check failed");
`else
`define FFA_ASSERT_IMP(label, ante, cons)
`define FFA_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ design/ffa_pkg.sv @@
// shared types and constants for the first-fit free-list allocator
// item structs, datapath command and status, controller states; no dependencies
package ffa_pkg;

    localparam int ADDR_BITS      = 25;
    localparam int LEN_BITS       = ADDR_BITS + 1;
    localparam int NODE_COUNT_DEF = 20;

    localparam logic [LEN_BITS-1:0] BLOCK_RESET = LEN_BITS'(33554432);
    localparam logic                OP_ALLOC    = 1'b0;
    localparam logic                OP_FREE     = 1'b1;

    typedef struct packed {
        logic                opcode;
        logic [LEN_BITS-1:0]  req_size;
        logic [LEN_BITS-1:0]  req_align;
        logic [ADDR_BITS-1:0] free_address;
        logic [LEN_BITS-1:0]  free_padding;
    } in_item_t;

    typedef struct packed {
        logic [1:0]           status;
        logic [ADDR_BITS-1:0] grant_address;
        logic [LEN_BITS-1:0]  grant_padding;
    } out_item_t;

    typedef enum logic [1:0] {
        RES_OK    = 2'd0,
        RES_NOFIT = 2'd1,
        RES_POOL  = 2'd2
    } res_code_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_LATCH,
        DP_STEP,
        DP_ALIGN,
        DP_PAD,
        DP_TAKE,
        DP_ALLOC_WR,
        DP_NEW_HEAD,
        DP_MATCH,
        DP_SUM1,
        DP_SUM2,
        DP_MERGE_WR,
        DP_INS_NODE,
        DP_INS_LINK,
        DP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t    op;
        res_code_t code;
    } dp_cmd_t;

    typedef struct packed {
        logic is_free;
        logic bsize_zero;
        logic list_empty;
        logic cur_null;
        logic steps_full;
        logic steps_over;
        logic fit;
        logic stop;
        logic pool_full;
        logic pa;
        logic na;
        logic out_free;
    } dp_stat_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DISPATCH,
        S_A_WALK,
        S_A_PAD,
        S_A_TAKE,
        S_A_UPD,
        S_F_GRAB,
        S_F_WALK,
        S_F_ROUTE,
        S_F_SUM2,
        S_F_MERGE,
        S_F_LINK,
        S_DONE
    } state_t;

endpackage

@@ design/ffa_ram.sv @@
// generic single-write, single-read ram with registered read data
// depends on ffa_pkg for parameter defaults
module ffa_ram
    import ffa_pkg::*;
#(
    parameter int WIDTH = LEN_BITS,
    parameter int DEPTH = NODE_COUNT_DEF
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/ffa_ctrl.sv @@
// controller state machine for the first-fit free-list allocator
// issues datapath commands from datapath status; depends on ffa_pkg
module ffa_ctrl
    import ffa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd,
    output logic     idle
);

    state_t    state_reg, state_next;
    res_code_t code_reg, code_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            code_reg  <= RES_OK;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        code_next  = code_reg;
        cmd.op     = DP_NOP;
        cmd.code   = code_reg;
        idle       = 1'b0;
        case (state_reg)
            S_INIT:
            begin
                cmd.op     = DP_LOAD;
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                idle = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = DP_LATCH;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (!stat.is_free)
                begin
                    state_next = S_A_WALK;
                end
                else if (stat.bsize_zero)
                begin
                    code_next  = RES_OK;
                    state_next = S_DONE;
                end
                else if (stat.list_empty)
                begin
                    state_next = S_F_GRAB;
                end
                else
                begin
                    state_next = S_F_WALK;
                end
            end
            S_A_WALK:
            begin
                if (stat.cur_null || stat.steps_full)
                begin
                    code_next  = RES_NOFIT;
                    state_next = S_DONE;
                end
                else if (stat.fit)
                begin
                    cmd.op     = DP_ALIGN;
                    state_next = S_A_PAD;
                end
                else
                begin
                    cmd.op = DP_STEP;
                end
            end
            S_A_PAD:
            begin
                cmd.op     = DP_PAD;
                state_next = S_A_TAKE;
            end
            S_A_TAKE:
            begin
                cmd.op     = DP_TAKE;
                state_next = S_A_UPD;
            end
            S_A_UPD:
            begin
                cmd.op     = DP_ALLOC_WR;
                code_next  = RES_OK;
                state_next = S_DONE;
            end
            S_F_GRAB:
            begin
                if (stat.pool_full)
                begin
                    code_next = RES_POOL;
                end
                else
                begin
                    cmd.op    = DP_NEW_HEAD;
                    code_next = RES_OK;
                end
                state_next = S_DONE;
            end
            S_F_WALK:
            begin
                if (stat.steps_over)
                begin
                    code_next  = RES_OK;
                    state_next = S_DONE;
                end
                else if (stat.cur_null || stat.stop)
                begin
                    cmd.op     = DP_MATCH;
                    state_next = S_F_ROUTE;
                end
                else
                begin
                    cmd.op = DP_STEP;
                end
            end
            S_F_ROUTE:
            begin
                if (stat.pa || stat.na)
                begin
                    cmd.op     = DP_SUM1;
                    state_next = S_F_SUM2;
                end
                else if (stat.pool_full)
                begin
                    code_next  = RES_POOL;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = DP_INS_NODE;
                    state_next = S_F_LINK;
                end
            end
            S_F_SUM2:
            begin
                cmd.op     = DP_SUM2;
                state_next = S_F_MERGE;
            end
            S_F_MERGE:
            begin
                cmd.op     = DP_MERGE_WR;
                code_next  = RES_OK;
                state_next = S_DONE;
            end
            S_F_LINK:
            begin
                cmd.op     = DP_INS_LINK;
                code_next  = RES_OK;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = DP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

endmodule

@@ design/ffa_dpath.sv @@
// datapath for the first-fit free-list allocator: node ram, list pointers,
// arithmetic registers and the output item register; depends on ffa_pkg, ffa_ram
module ffa_dpath
    import ffa_pkg::*;
#(
    parameter int NODE_COUNT = NODE_COUNT_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  in_item_t            in_data,
    input  logic                cfg_write,
    input  logic [LEN_BITS-1:0] cfg_data,
    input  dp_cmd_t             cmd,
    output dp_stat_t            stat,
    input  logic                out_stall,
    output logic                out_valid,
    output out_item_t           out_data
);

    localparam int IDX_W  = $clog2(NODE_COUNT);
    localparam int LINK_W = $clog2(NODE_COUNT + 1);
    localparam int STEP_W = $clog2(NODE_COUNT + 2);
    localparam int NODE_W = ADDR_BITS + LEN_BITS + LINK_W;

    localparam logic [LINK_W-1:0]   LINK_NULL = LINK_W'(NODE_COUNT);
    localparam logic [LEN_BITS-1:0] LEN_MAX   = '1;

    // node ram port
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [NODE_W-1:0] ram_wdata;
    logic [IDX_W-1:0]  ram_raddr;
    logic [NODE_W-1:0] ram_rdata;
    logic [LINK_W-1:0] rd_sel;

    logic [ADDR_BITS-1:0] rd_start;
    logic [LEN_BITS-1:0]  rd_len;
    logic [LINK_W-1:0]    rd_link;

    // control state
    logic [LEN_BITS-1:0]   block_reg, block_next;
    logic [NODE_COUNT-1:0] valid_reg, valid_next;
    logic [LINK_W-1:0]     head_reg, head_next;
    logic                  nonempty_reg, nonempty_next;
    logic                  out_valid_reg, out_valid_next;

    // per-item working registers
    logic                  is_free_reg;
    logic [LEN_BITS-1:0]   size_reg;
    logic [LEN_BITS:0]     sum_reg;
    logic [LEN_BITS-1:0]   mask_reg;
    logic [ADDR_BITS-1:0]  baddr_reg;
    logic [LEN_BITS-1:0]   bsize_reg;
    logic [LINK_W-1:0]     cur_reg;
    logic [LINK_W-1:0]     prev_reg;
    logic [ADDR_BITS-1:0]  prev_start_reg;
    logic [LEN_BITS-1:0]   prev_len_reg;
    logic [STEP_W-1:0]     steps_reg;
    logic [LEN_BITS:0]     acc_reg;
    logic [LEN_BITS-1:0]   pad_reg;
    logic [ADDR_BITS-1:0]  addr_reg;
    logic                  pa_reg;
    logic                  na_reg;
    logic [LEN_BITS-1:0]   merged_reg;
    logic [LINK_W-1:0]     new_reg;
    out_item_t             out_reg;

    // combinational helpers
    logic                  load_en;
    logic [LEN_BITS-1:0]   load_len;
    logic [IDX_W-1:0]      cur_idx;
    logic [IDX_W-1:0]      prev_idx;
    logic [IDX_W-1:0]      free_idx;
    logic                  pool_full;
    logic [LEN_BITS-1:0]   align_eff;
    logic [LEN_BITS:0]     bsize_sum;
    logic [LEN_BITS-1:0]   bsize_sat;
    logic [LEN_BITS:0]     afull;
    logic [LEN_BITS:0]     pad_full;
    logic [LEN_BITS:0]     new_len;
    logic [ADDR_BITS-1:0]  new_start;
    logic [LEN_BITS:0]     prev_end;
    logic [LEN_BITS:0]     blk_end;
    logic                  pa_hit;
    logic                  na_hit;
    logic [LEN_BITS:0]     sum1;
    logic [LEN_BITS+1:0]   sum2;
    logic [LEN_BITS-1:0]   merged_sat;
    logic                  grant_ok;

    assign rd_start = ram_rdata[NODE_W-1 -: ADDR_BITS];
    assign rd_len   = ram_rdata[LEN_BITS+LINK_W-1 -: LEN_BITS];
    assign rd_link  = ram_rdata[LINK_W-1:0];

    assign cur_idx  = cur_reg[IDX_W-1:0];
    assign prev_idx = prev_reg[IDX_W-1:0];
    assign load_en  = cfg_write || (cmd.op == DP_LOAD);
    assign load_len = cfg_write ? cfg_data : block_reg;

    // lowest free node in the pool
    always_comb
    begin
        free_idx  = '0;
        pool_full = 1'b1;
        for (int i = NODE_COUNT - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx  = IDX_W'(i);
                pool_full = 1'b0;
            end
        end
    end

    assign align_eff  = (in_data.req_align == '0) ? LEN_BITS'(1) : in_data.req_align;
    assign bsize_sum  = {1'b0, in_data.req_size} + {1'b0, in_data.free_padding};
    assign bsize_sat  = bsize_sum[LEN_BITS] ? LEN_MAX : bsize_sum[LEN_BITS-1:0];
    assign afull      = ({2'b00, rd_start} + {1'b0, mask_reg}) & ~{1'b0, mask_reg};
    assign pad_full   = acc_reg - {2'b00, rd_start};
    assign new_len    = {1'b0, rd_len} - acc_reg;
    assign new_start  = rd_start + acc_reg[ADDR_BITS-1:0];
    assign prev_end   = {2'b00, prev_start_reg} + {1'b0, prev_len_reg};
    assign blk_end    = {2'b00, baddr_reg} + {1'b0, bsize_reg};
    assign pa_hit     = (prev_reg != LINK_NULL) && (prev_end == {2'b00, baddr_reg});
    assign na_hit     = (cur_reg != LINK_NULL) && (blk_end == {2'b00, rd_start});
    assign sum1       = {1'b0, (pa_reg ? prev_len_reg : rd_len)} + {1'b0, bsize_reg};
    assign sum2       = {1'b0, acc_reg} + {2'b00, ((pa_reg && na_reg) ? rd_len : LEN_BITS'(0))};
    assign merged_sat = (sum2 > {2'b00, LEN_MAX}) ? LEN_MAX : sum2[LEN_BITS-1:0];
    assign grant_ok   = !is_free_reg && (cmd.code == RES_OK);

    // read address follows the walk
    always_comb
    begin
        rd_sel = cur_reg;
        if (cmd.op == DP_LATCH)
        begin
            rd_sel = head_reg;
        end
        else if (cmd.op == DP_STEP)
        begin
            rd_sel = rd_link;
        end
        ram_raddr = (rd_sel == LINK_NULL) ? '0 : rd_sel[IDX_W-1:0];
    end

    // node writes
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = {{ADDR_BITS{1'b0}}, {LEN_BITS{1'b0}}, LINK_NULL};
        if (load_en)
        begin
            ram_we    = 1'b1;
            ram_wdata = {{ADDR_BITS{1'b0}}, load_len, LINK_NULL};
        end
        else
        begin
            case (cmd.op)
                DP_ALLOC_WR:
                begin
                    ram_we    = 1'b1;
                    ram_waddr = cur_idx;
                    ram_wdata = {new_start, new_len[LEN_BITS-1:0], rd_link};
                end
                DP_NEW_HEAD:
                begin
                    ram_we    = 1'b1;
                    ram_waddr = free_idx;
                    ram_wdata = {baddr_reg, bsize_reg, LINK_NULL};
                end
                DP_MERGE_WR:
                begin
                    ram_we = 1'b1;
                    if (pa_reg)
                    begin
                        ram_waddr = prev_idx;
                        ram_wdata = {prev_start_reg, merged_reg, (na_reg ? rd_link : cur_reg)};
                    end
                    else
                    begin
                        ram_waddr = cur_idx;
                        ram_wdata = {baddr_reg, merged_reg, rd_link};
                    end
                end
                DP_INS_NODE:
                begin
                    ram_we    = 1'b1;
                    ram_waddr = free_idx;
                    ram_wdata = {baddr_reg, bsize_reg, cur_reg};
                end
                DP_INS_LINK:
                begin
                    ram_we    = (prev_reg != LINK_NULL);
                    ram_waddr = prev_idx;
                    ram_wdata = {prev_start_reg, prev_len_reg, new_reg};
                end
                default:
                begin
                    ram_we = 1'b0;
                end
            endcase
        end
    end

    // list control next state
    always_comb
    begin
        block_next     = cfg_write ? cfg_data : block_reg;
        valid_next     = valid_reg;
        head_next      = head_reg;
        nonempty_next  = nonempty_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (load_en)
        begin
            valid_next    = '0;
            valid_next[0] = (load_len != '0);
            head_next     = '0;
            nonempty_next = (load_len != '0);
        end
        else
        begin
            case (cmd.op)
                DP_NEW_HEAD:
                begin
                    valid_next[free_idx] = 1'b1;
                    head_next            = LINK_W'(free_idx);
                    nonempty_next        = 1'b1;
                end
                DP_MERGE_WR:
                begin
                    if (pa_reg && na_reg)
                    begin
                        valid_next[cur_idx] = 1'b0;
                    end
                end
                DP_INS_NODE:
                begin
                    valid_next[free_idx] = 1'b1;
                end
                DP_INS_LINK:
                begin
                    if (prev_reg == LINK_NULL)
                    begin
                        head_next = new_reg;
                    end
                end
                default:
                begin
                    head_next = head_reg;
                end
            endcase
        end
        if (cmd.op == DP_EMIT)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_reg     <= BLOCK_RESET;
            valid_reg     <= '0;
            head_reg      <= '0;
            nonempty_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            block_reg     <= block_next;
            valid_reg     <= valid_next;
            head_reg      <= head_next;
            nonempty_reg  <= nonempty_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            DP_LATCH:
            begin
                is_free_reg <= (in_data.opcode == OP_FREE);
                size_reg    <= in_data.req_size;
                sum_reg     <= {1'b0, in_data.req_size} + {1'b0, align_eff};
                mask_reg    <= align_eff - LEN_BITS'(1);
                baddr_reg   <= in_data.free_address - in_data.free_padding[ADDR_BITS-1:0];
                bsize_reg   <= bsize_sat;
                cur_reg     <= nonempty_reg ? head_reg : LINK_NULL;
                prev_reg    <= LINK_NULL;
                steps_reg   <= '0;
            end
            DP_STEP:
            begin
                prev_reg       <= cur_reg;
                prev_start_reg <= rd_start;
                prev_len_reg   <= rd_len;
                cur_reg        <= rd_link;
                steps_reg      <= steps_reg + STEP_W'(1);
            end
            DP_ALIGN:
            begin
                acc_reg <= afull;
            end
            DP_PAD:
            begin
                pad_reg  <= pad_full[LEN_BITS-1:0];
                addr_reg <= acc_reg[ADDR_BITS-1:0];
            end
            DP_TAKE:
            begin
                acc_reg <= {1'b0, size_reg} + {1'b0, pad_reg};
            end
            DP_MATCH:
            begin
                pa_reg <= pa_hit;
                na_reg <= na_hit;
            end
            DP_SUM1:
            begin
                acc_reg <= sum1;
            end
            DP_SUM2:
            begin
                merged_reg <= merged_sat;
            end
            DP_INS_NODE:
            begin
                new_reg <= LINK_W'(free_idx);
            end
            DP_EMIT:
            begin
                out_reg.status        <= cmd.code;
                out_reg.grant_address <= grant_ok ? addr_reg : '0;
                out_reg.grant_padding <= grant_ok ? pad_reg : '0;
            end
            default:
            begin
                new_reg <= new_reg;
            end
        endcase
    end

    ffa_ram #(
        .WIDTH (NODE_W),
        .DEPTH (NODE_COUNT)
    ) u_node_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign stat.is_free    = is_free_reg;
    assign stat.bsize_zero = (bsize_reg == '0);
    assign stat.list_empty = !nonempty_reg;
    assign stat.cur_null   = (cur_reg == LINK_NULL);
    assign stat.steps_full = (steps_reg == STEP_W'(NODE_COUNT));
    assign stat.steps_over = (steps_reg == STEP_W'(NODE_COUNT + 1));
    assign stat.fit        = ({1'b0, rd_len} >= sum_reg);
    assign stat.stop       = (rd_start > baddr_reg);
    assign stat.pool_full  = pool_full;
    assign stat.pa         = pa_reg;
    assign stat.na         = na_reg;
    assign stat.out_free   = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

@@ design/first_fit_free_list_allocator.sv @@
// top level of the first-fit free-list allocator with coalescing
// joins ffa_ctrl and ffa_dpath; depends on ffa_pkg and the assertion header
//
//  channel   signals                          item           accepted when
//  in        in_valid, in_stall, in_data      in_item_t      in_valid && !in_stall
//  out       out_valid, out_stall, out_data   out_item_t     out_valid && !out_stall
//  cfg       cfg_valid, cfg_ready, cfg_data   block_bytes    cfg_valid && cfg_ready
//
// one item at a time: an allocate or a free steps past the nodes of the free list,
// one node per cycle through the node ram port.
// after reset the init state loads the whole block as a single extent; a cfg write does the same.
// cfg_ready is low while an item is offered or in flight.
// in_stall stays high from acceptance until the result is placed in the output register;
// a result waiting on out_stall lets the next item in, and its own result waits behind it.
`include "first_fit_free_list_allocator_assert.svh"

module first_fit_free_list_allocator
    import ffa_pkg::*;
#(
    parameter int NODE_COUNT = NODE_COUNT_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  in_item_t            in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output out_item_t           out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [LEN_BITS-1:0] cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     idle;
    logic     cfg_write;

    assign in_stall  = !idle;
    assign cfg_ready = idle && !in_valid;
    assign cfg_write = cfg_valid && cfg_ready;

    ffa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .stat     (stat),
        .cmd      (cmd),
        .idle     (idle)
    );

    ffa_dpath #(
        .NODE_COUNT (NODE_COUNT)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    `FFA_ASSERT_IMP(a_emit_needs_room, cmd.op == DP_EMIT, stat.out_free)
    `FFA_ASSERT_NEXT(a_emit_shows_valid, cmd.op == DP_EMIT, out_valid)
    `FFA_ASSERT_NEXT(a_accept_goes_busy, in_valid && !in_stall, in_stall)

endmodule
